[design/bsf_pkg.sv]
// ----------------------------------------------------------------------------
// bsf_pkg: shared types and constants of the byte stuffing framer
// Holds the command word passed from the classifier to the expander, the
// clamped configuration bundle, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package bsf_pkg;

  // Default lookahead depth; the top level hands it down as a parameter.
  localparam int MaxPatternLenDefault = 4;

  // Longest stuff string the framer supports, and the clamp it implies.
  localparam int MaxStuffLen = 2;
  localparam int StuffCap    = (MaxStuffLen < 2) ? MaxStuffLen : 2;

  // The fixed text "esc", first character in the lowest byte.
  localparam logic [23:0] EscBytes = 24'h637365;
  localparam logic [2:0]  EscLen   = 3'd3;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgStartPattern = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartLength  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEndPattern   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEndLength    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStuffPattern = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStuffLength  = 3'd5;

  // Command queue depth between classifier and expander (power of two).
  localparam int QueueDepth = 4;

  // Configuration with lengths already clamped to what the framer supports.
  typedef struct packed {
    logic [31:0] start_pattern;
    logic [2:0]  start_len;
    logic [31:0] end_pattern;
    logic [2:0]  end_len;
    logic [15:0] stuff_pattern;
    logic [1:0]  stuff_len;
  } bsf_cfg_t;

  // One command describes a run of output words: an optional start
  // delimiter, up to three stuff strings, an optional payload byte and an
  // optional end delimiter. Every queued command yields at least one word.
  typedef struct packed {
    logic       pre_start;
    logic       emit_byte;
    logic [7:0] data;
    logic [2:0] stuff_hits;  // bit 0 start, bit 1 end, bit 2 "esc"
    logic       post_end;
    logic       run_last;
  } bsf_cmd_t;

  // Output phases of one command, in emission order.
  localparam int NumPhases = 6;

  typedef enum logic [2:0] {
    PhStart,
    PhStuff0,
    PhStuff1,
    PhStuff2,
    PhByte,
    PhEnd
  } bsf_phase_e;

endpackage

[design/byte_stuffing_framer.sv]
// ----------------------------------------------------------------------------
// byte_stuffing_framer: delimits and byte-stuffs a stream of payload bytes
//
// Channel   Direction  Handshake              Word
// input     in         in_valid_i/in_stall_o   payload_byte_i, frame_last_i
// output    out        out_valid_o/out_stall_i out_byte_o, run_last_o,
//                                              frame_end_o
// config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// An input word is taken every cycle while the command queue has room and the
// window is not draining. The last word of a frame holds the input while the
// lookahead window drains. The expander gives one output word per cycle while
// a command is queued and the output is not stalled, so a word that draws
// stuffing or a delimiter holds back the input through the queue. Reset is
// asynchronous and active low, restores the register defaults and empties
// window and queue at once, with no clearing pass.
// ----------------------------------------------------------------------------
module byte_stuffing_framer #(
  parameter int MAX_PATTERN_LEN = bsf_pkg::MaxPatternLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   payload_byte_i,
  input  logic                         frame_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         run_last_o,
  output logic                         frame_end_o,
  input  logic                         cfg_we_i,
  input  logic [bsf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bsf_pkg::CfgDataW-1:0] cfg_data_i
);
  import bsf_pkg::*;

  // Delimiters are clamped to the window depth and to four bytes.
  localparam int DelimCap = (MAX_PATTERN_LEN < 4) ? MAX_PATTERN_LEN : 4;

  // Configuration registers, as written by software.
  logic [31:0] start_pattern_q;
  logic [2:0]  start_length_q;
  logic [31:0] end_pattern_q;
  logic [2:0]  end_length_q;
  logic [15:0] stuff_pattern_q;
  logic [1:0]  stuff_length_q;

  bsf_cfg_t cfg;
  logic     push, pop, full, empty;
  bsf_cmd_t cmd, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pattern_q <= 32'd126;
      start_length_q  <= 3'd1;
      end_pattern_q   <= 32'd126;
      end_length_q    <= 3'd1;
      stuff_pattern_q <= 16'd125;
      stuff_length_q  <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStartPattern: start_pattern_q <= cfg_data_i;
        CfgStartLength:  start_length_q  <= cfg_data_i[2:0];
        CfgEndPattern:   end_pattern_q   <= cfg_data_i;
        CfgEndLength:    end_length_q    <= cfg_data_i[2:0];
        CfgStuffPattern: stuff_pattern_q <= cfg_data_i[15:0];
        CfgStuffLength:  stuff_length_q  <= cfg_data_i[1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Lengths above what the framer supports saturate; a zero length means
  // the string is empty and never matches.
  always_comb begin
    cfg.start_pattern = start_pattern_q;
    cfg.start_len     = (start_length_q > 3'(DelimCap)) ? 3'(DelimCap) : start_length_q;
    cfg.end_pattern   = end_pattern_q;
    cfg.end_len       = (end_length_q > 3'(DelimCap)) ? 3'(DelimCap) : end_length_q;
    cfg.stuff_pattern = stuff_pattern_q;
    cfg.stuff_len     = (stuff_length_q > 2'(StuffCap)) ? 2'(StuffCap) : stuff_length_q;
  end

  // Classifier: window, match decisions, one command per cycle while the queue has room.
  bsf_front #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_byte_i(payload_byte_i),
    .frame_last_i  (frame_last_i),
    .cfg_i         (cfg),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  // Short queue so that stuffing on the output side does not stall the
  // classifier right away.
  bsf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  // Expander: one output word per cycle into the output register while not stalled.
  bsf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .frame_end_o(frame_end_o)
  );

endmodule

[design/bsf_front.sv]
// ----------------------------------------------------------------------------
// bsf_front: input classifier of the byte stuffing framer
// Keeps the lookahead window, decides pattern matches at its oldest byte and
// pushes one command per cycle into the command queue while it has room.
// ----------------------------------------------------------------------------
module bsf_front #(
  parameter int MAX_PATTERN_LEN = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        payload_byte_i,
  input  logic              frame_last_i,
  input  bsf_pkg::bsf_cfg_t cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output bsf_pkg::bsf_cmd_t cmd_o
);
  import bsf_pkg::*;

  localparam int CntW     = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CmpW     = CntW + 1;
  localparam int DelimCap = (MAX_PATTERN_LEN < 4) ? MAX_PATTERN_LEN : 4;
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_PATTERN_LEN);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef logic [MAX_PATTERN_LEN-1:0][7:0] win_t;

  // A pattern matches when it is non-empty, fits in the known bytes and
  // equals the window from its oldest byte on.
  function automatic logic hit(input win_t w, input logic [CntW-1:0] cnt,
                               input logic [31:0] pat, input logic [2:0] len);
    logic ok;
    ok = (len != 3'd0) && (CmpW'(len) <= CmpW'(cnt));
    for (int i = 0; i < DelimCap; i++) begin
      if ((3'(i) < len) && (w[i] != pat[8*i +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  win_t            win_q, win_d, nwin, hwin;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_eff, ncnt, hcnt;
  logic            inside_q, inside_d;
  logic            flush_q, flush_d;
  logic            pend_start_q, pend_start_d;
  logic            pre_now, accept, stuff_on;
  logic [2:0]      hits;

  always_comb begin
    cnt_eff = inside_q ? cnt_q : '0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
      nwin[i] = (CntW'(i) == cnt_eff) ? payload_byte_i : win_q[i];
    end
    ncnt    = cnt_eff + CntOne;
    pre_now = !inside_q && (cfg_i.start_len != 3'd0);

    in_stall_o = flush_q || full_i;
    accept     = in_valid_i && !in_stall_o;

    // One set of comparators serves both the flush and the normal path.
    hwin     = flush_q ? win_q : nwin;
    hcnt     = flush_q ? cnt_q : CntFull;
    stuff_on = cfg_i.stuff_len != 2'd0;
    hits     = {hit(hwin, hcnt, {8'h00, EscBytes}, EscLen),
                hit(hwin, hcnt, cfg_i.end_pattern, cfg_i.end_len),
                hit(hwin, hcnt, cfg_i.start_pattern, cfg_i.start_len)}
               & {3{stuff_on}};
  end

  always_comb begin
    win_d        = win_q;
    cnt_d        = cnt_q;
    inside_d     = inside_q;
    flush_d      = flush_q;
    pend_start_d = pend_start_q;
    push_o       = 1'b0;

    cmd_o.pre_start  = pre_now;
    cmd_o.emit_byte  = 1'b1;
    cmd_o.data       = hwin[0];
    cmd_o.stuff_hits = hits;
    cmd_o.post_end   = 1'b0;
    cmd_o.run_last   = 1'b1;

    if (flush_q) begin
      // Drain the window one byte per cycle while the queue has room; the
      // final one carries the end delimiter.
      cmd_o.pre_start = pend_start_q;
      cmd_o.post_end  = (cnt_q == CntOne) && (cfg_i.end_len != 3'd0);
      cmd_o.run_last  = cnt_q == CntOne;
      if (!full_i) begin
        push_o       = 1'b1;
        pend_start_d = 1'b0;
        win_d        = {8'h00, win_q[MAX_PATTERN_LEN-1:1]};
        cnt_d        = cnt_q - CntOne;
        if (cnt_q == CntOne) begin
          flush_d  = 1'b0;
          inside_d = 1'b0;
        end
      end
    end else if (accept) begin
      inside_d = 1'b1;
      if (frame_last_i) begin
        win_d        = nwin;
        cnt_d        = ncnt;
        flush_d      = 1'b1;
        pend_start_d = pre_now;
      end else if (ncnt == CntFull) begin
        push_o = 1'b1;
        win_d  = {8'h00, nwin[MAX_PATTERN_LEN-1:1]};
        cnt_d  = CntFull - CntOne;
      end else begin
        win_d            = nwin;
        cnt_d            = ncnt;
        push_o           = pre_now;
        cmd_o.emit_byte  = 1'b0;
        cmd_o.stuff_hits = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      inside_q     <= 1'b0;
      flush_q      <= 1'b0;
      pend_start_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      inside_q     <= inside_d;
      flush_q      <= flush_d;
      pend_start_q <= pend_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

[design/bsf_queue.sv]
// ----------------------------------------------------------------------------
// bsf_queue: command queue of the byte stuffing framer
// A short first-in first-out buffer that decouples the classifier from the
// expander so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bsf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsf_pkg::bsf_cmd_t cmd_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output bsf_pkg::bsf_cmd_t head_o
);
  import bsf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam logic [PtrW:0] CntMax = (PtrW + 1)'(QueueDepth);

  bsf_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = cnt_q == CntMax;
    empty_o = cnt_q == '0;
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    head_o  = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[design/bsf_back.sv]
// ----------------------------------------------------------------------------
// bsf_back: output expander of the byte stuffing framer
// Turns each queued command into its run of output words, one word per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module bsf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsf_pkg::bsf_cfg_t cfg_i,
  input  bsf_pkg::bsf_cmd_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              frame_end_o
);
  import bsf_pkg::*;

  logic [NumPhases-1:0] rem_q, rem_d, act, rem, rem_after;
  logic                 started_q, started_d;
  logic [1:0]           idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 run_last_q, run_last_d;
  logic                 frame_end_q, frame_end_d;
  bsf_phase_e           cur;
  logic [2:0]           len;
  logic [7:0]           sel_byte;
  logic                 phase_done, cmd_done, load, advance;

  always_comb begin
    act = {head_i.post_end, head_i.emit_byte, head_i.stuff_hits, head_i.pre_start};
    rem = started_q ? rem_q : act;

    // The lowest pending phase is the one being emitted.
    cur = PhEnd;
    for (int i = NumPhases - 1; i >= 0; i--) begin
      if (rem[i]) begin
        cur = bsf_phase_e'(3'(i));
      end
    end

    unique case (cur)
      PhStart: begin
        len      = cfg_i.start_len;
        sel_byte = cfg_i.start_pattern[8*idx_q +: 8];
      end
      PhStuff0, PhStuff1, PhStuff2: begin
        len      = {1'b0, cfg_i.stuff_len};
        sel_byte = cfg_i.stuff_pattern[8*idx_q[0] +: 8];
      end
      PhByte: begin
        len      = 3'd1;
        sel_byte = head_i.data;
      end
      PhEnd: begin
        len      = cfg_i.end_len;
        sel_byte = cfg_i.end_pattern[8*idx_q +: 8];
      end
      default: begin
        len      = 3'd1;
        sel_byte = head_i.data;
      end
    endcase

    phase_done = ({1'b0, idx_q} + 3'd1) == len;
    rem_after  = rem & ~(NumPhases'(1) << cur);
    cmd_done   = phase_done && (rem_after == '0);

    load    = !out_valid_q || !out_stall_i;
    advance = !empty_i && load;
    pop_o   = advance && cmd_done;
  end

  always_comb begin
    rem_d       = rem_q;
    started_d   = started_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    frame_end_d = frame_end_q;

    if (load) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      run_last_d  = head_i.run_last && cmd_done;
      frame_end_d = (cur == PhEnd) && phase_done;
      if (phase_done) begin
        idx_d     = 2'd0;
        rem_d     = rem_after;
        started_d = !cmd_done;
      end else begin
        idx_d     = idx_q + 2'd1;
        rem_d     = rem;
        started_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      started_q   <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      started_q   <= started_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

[tb/framed_stream_pkg.sv]
// ----------------------------------------------------------------------------
// framed_stream_pkg: expected framed byte stream of the byte stuffing framer
// Mirrors the framer's registers, lookahead window and frame state, turns
// every accepted payload word into the framed words it must produce, and
// compares the words that come out against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package framed_stream_pkg;
  import bsf_pkg::*;

  localparam int WindowDepth = MaxPatternLenDefault;
  localparam int DelimCap    = (WindowDepth < 4) ? WindowDepth : 4;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } framed_word_t;

  class framed_stream;
    logic [31:0] start_pat;
    logic [2:0]  start_len;
    logic [31:0] end_pat;
    logic [2:0]  end_len;
    logic [15:0] stuff_pat;
    logic [1:0]  stuff_len;

    logic [7:0]  window [WindowDepth];
    int          fill;
    bit          in_frame;

    framed_word_t pending_words [$];
    framed_word_t run_words [$];

    int words_in;
    int frames_in;
    int words_out;
    int stuff_runs;
    int errors;

    function new();
      start_pat  = 32'd126;
      start_len  = 3'd1;
      end_pat    = 32'd126;
      end_len    = 3'd1;
      stuff_pat  = 16'd125;
      stuff_len  = 2'd1;
      fill       = 0;
      in_frame   = 1'b0;
      words_in   = 0;
      frames_in  = 0;
      words_out  = 0;
      stuff_runs = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgStartPattern: start_pat = value;
        CfgStartLength:  start_len = value[2:0];
        CfgEndPattern:   end_pat   = value;
        CfgEndLength:    end_len   = value[2:0];
        CfgStuffPattern: stuff_pat = value[15:0];
        CfgStuffLength:  stuff_len = value[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function int clamp(int len, int cap);
      return (len > cap) ? cap : len;
    endfunction

    function void put_word(logic [7:0] data, logic frame_end);
      run_words.push_back('{data: data, run_last: 1'b0, frame_end: frame_end});
    endfunction

    function void put_bytes(logic [31:0] pattern, int len, bit mark_end);
      for (int i = 0; i < len; i++)
        put_word(8'(pattern >> (8 * i)), mark_end && (i == len - 1));
    endfunction

    // A pattern counts only when all of its bytes are already in the window.
    function bit starts_at_front(logic [31:0] pattern, int len);
      if (len == 0 || len > fill)
        return 1'b0;
      for (int i = 0; i < len; i++)
        if (window[i] != 8'(pattern >> (8 * i)))
          return 1'b0;
      return 1'b1;
    endfunction

    function void insert_stuffing();
      put_bytes(stuff_pat, clamp(stuff_len, StuffCap), 1'b0);
      stuff_runs++;
    endfunction

    function void emit_front();
      if (starts_at_front(start_pat, clamp(start_len, DelimCap)))
        insert_stuffing();
      if (starts_at_front(end_pat, clamp(end_len, DelimCap)))
        insert_stuffing();
      if (starts_at_front(32'(EscBytes), EscLen))
        insert_stuffing();
      put_word(window[0], 1'b0);
      for (int i = 1; i < fill; i++)
        window[i - 1] = window[i];
      fill--;
    endfunction

    function void note_word(logic [7:0] data, logic is_last);
      framed_word_t tail;
      run_words.delete();
      words_in++;
      if (!in_frame) begin
        put_bytes(start_pat, clamp(start_len, DelimCap), 1'b0);
        in_frame = 1'b1;
        fill     = 0;
      end
      if (fill >= WindowDepth)
        emit_front();
      window[fill] = data;
      fill++;
      if (is_last) begin
        while (fill > 0)
          emit_front();
        put_bytes(end_pat, clamp(end_len, DelimCap), 1'b1);
        in_frame = 1'b0;
        frames_in++;
      end else if (fill >= WindowDepth) begin
        emit_front();
      end
      if (run_words.size() > 0) begin
        tail = run_words.pop_back();
        tail.run_last = 1'b1;
        run_words.push_back(tail);
      end
      foreach (run_words[i])
        pending_words.push_back(run_words[i]);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= ReportLimit)
        $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_word(logic [7:0] data, logic run_last, logic frame_end);
      framed_word_t want;
      words_out++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %02h run_last=%b frame_end=%b",
                         data, run_last, frame_end));
        return;
      end
      want = pending_words.pop_front();
      if (want.data !== data || want.run_last !== run_last ||
          want.frame_end !== frame_end)
        report($sformatf("word %0d: expected %02h/%b/%b, got %02h/%b/%b (byte/run_last/frame_end)",
                         words_out, want.data, want.run_last, want.frame_end,
                         data, run_last, frame_end));
    endfunction
  endclass

endpackage

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the byte stuffing framer
// Feeds framed payload words under several register settings, with random
// idling on both channels, and checks every framed output word against the
// expected stream kept by framed_stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bsf_pkg::*;
  import framed_stream_pkg::*;

  // Minimum number of random payload words after the directed frames.
  localparam int RandomWords = 130;
  // Quiet cycles after the last expected word: covers the window drain and
  // the command queue, with margin.
  localparam int SettleCycles = 16;
  localparam int MaxGap = 4;
  localparam int FramesPerSetting = 4;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [7:0]          payload_byte_i = 8'h00;
  logic                frame_last_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [7:0]          out_byte_o;
  logic                run_last_o;
  logic                frame_end_o;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // Expected framed stream, shared by the monitor and the stimulus.
  framed_stream stream;

  // When set, neither side idles: the block runs at full rate.
  bit no_gaps = 1'b0;
  int settings_used = 1;

  byte_stuffing_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop. The slowest correct run stays far below this: every word at
  // its largest expansion, every output word stalled for the longest random gap.
  initial begin
    #3_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Both handshakes are observed here at the rising edge. Noting the input
  // word before checking the output word keeps the result independent of
  // the order in which processes wake up at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        stream.note_word(payload_byte_i, frame_last_i);
      if (out_valid_o && !out_stall_i)
        stream.check_word(out_byte_o, run_last_o, frame_end_o);
    end
  end

  // Output side: before each word it stalls a random number of cycles,
  // then takes the word as soon as it is offered.
  initial begin : sink
    int hold;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      hold = no_gaps ? 0 : $urandom_range(0, MaxGap);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Offers one payload word after a random gap and returns once it has
  // been taken. Valid stays high afterwards, so a following word with no
  // gap is offered in the very next cycle, to be taken unless stalled.
  task automatic send_word(input logic [7:0] data, input logic is_last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= data;
    frame_last_i   <= is_last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_frame(input logic [7:0] frame [$], inout int sent);
    foreach (frame[i]) begin
      send_word(frame[i], i == frame.size() - 1);
      sent++;
    end
  endtask

  // Stops the input and waits until every expected word has come out, then
  // lets the block settle. Register writes only follow a call to this.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (stream.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    stream.write_reg(idx, value);
  endtask

  task automatic set_config(input logic [31:0] start_pat, input logic [2:0] start_len,
                            input logic [31:0] end_pat, input logic [2:0] end_len,
                            input logic [15:0] stuff_pat, input logic [1:0] stuff_len);
    write_reg(CfgStartPattern, start_pat);
    write_reg(CfgStartLength, 32'(start_len));
    write_reg(CfgEndPattern, end_pat);
    write_reg(CfgEndLength, 32'(end_len));
    write_reg(CfgStuffPattern, 32'(stuff_pat));
    write_reg(CfgStuffLength, 32'(stuff_len));
    settings_used++;
  endtask

  // Bytes for random patterns come from a small pool so that patterns
  // overlap each other and the "esc" text, which makes matches common.
  function automatic logic [7:0] pool_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h7E;
      1:       return 8'h7D;
      2:       return 8'(EscBytes >> (8 * $urandom_range(0, 2)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pool_pattern();
    return {pool_byte(), pool_byte(), pool_byte(), pool_byte()};
  endfunction

  // Walks through zero lengths, saturating lengths with all-ones and
  // all-zeros patterns, the usual single-byte flags with a two-byte stuff
  // string, and fully random settings.
  task automatic random_config(input int step);
    logic [31:0] start_pat;
    case (step % 4)
      0: set_config(pool_pattern(), 3'd0, pool_pattern(), 3'd0, 16'(pool_pattern()), 2'd0);
      1: set_config(32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd4, 16'hFFFF, 2'd3);
      2: set_config(32'h0000_007E, 3'd1, 32'h0000_007E, 3'd1,
                    16'($urandom_range(0, 65535)), 2'd2);
      default: begin
        start_pat = pool_pattern();
        set_config(start_pat, 3'($urandom_range(0, 7)),
                   ($urandom_range(0, 2) == 0) ? start_pat : pool_pattern(),
                   3'($urandom_range(0, 7)),
                   16'(pool_pattern()), 2'($urandom_range(0, 3)));
      end
    endcase
  endtask

  function automatic void append_pattern(ref logic [7:0] q [$], input logic [31:0] pattern,
                                         input int len);
    for (int i = 0; i < len && i < 4; i++)
      q.push_back(8'(pattern >> (8 * i)));
  endfunction

  // Random frame built mostly from whole delimiters, stuff strings and the
  // "esc" text, mixed with loose bytes. Cutting it to length often leaves a
  // partial pattern at the frame end, which must not match.
  function automatic void make_frame(ref logic [7:0] q [$]);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
    q.delete();
    while (q.size() < len) begin
      case ($urandom_range(0, 6))
        0: append_pattern(q, stream.start_pat, stream.start_len);
        1: append_pattern(q, stream.end_pat, stream.end_len);
        2: append_pattern(q, 32'(EscBytes), EscLen);
        3: append_pattern(q, 32'(stream.stuff_pat), stream.stuff_len);
        4: q.push_back(8'($urandom_range(0, 255)));
        5: q.push_back(pool_byte());
        default: q.push_back(8'(stream.start_pat >> (8 * $urandom_range(0, 3))));
      endcase
    end
    while (q.size() > len)
      void'(q.pop_back());
  endfunction

  initial begin : stimulus
    logic [7:0] frame [$];
    int sent;
    int directed;
    int step;
    sent   = 0;
    step   = 0;
    stream = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset settings: a one-word frame that is
    // itself the flag, both byte extremes, a flag that matches the start and
    // the end delimiter at once, the escape byte, "esc" inside a frame, "es"
    // cut off by the frame end, and "esc" ending exactly on the last word.
    frame = '{8'h7E};
    send_frame(frame, sent);
    frame = '{8'h00, 8'hFF, 8'h7E, 8'h7D, 8'h65, 8'h73, 8'h63};
    send_frame(frame, sent);
    frame = '{8'h65, 8'h73};
    send_frame(frame, sent);
    frame = '{8'h78, 8'h65, 8'h73, 8'h63};
    send_frame(frame, sent);
    drain();

    // Four-byte start delimiter, an end length that saturates to four and a
    // stuff length that saturates to two. The start delimiter appears once
    // whole and once cut short by the frame end.
    set_config(32'h6463_6261, 3'd4, 32'hDDCC_BBAA, 3'd7, 16'hBBAA, 2'd3);
    frame = '{8'h61, 8'h62, 8'h63, 8'h64, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h61, 8'h62, 8'h63};
    send_frame(frame, sent);
    directed = sent;

    // Random part: each setting gets a few frames, and every third setting
    // runs both channels without idling.
    while (sent < directed + RandomWords) begin
      drain();
      no_gaps = (step % 3 == 2);
      random_config(step);
      repeat (FramesPerSetting) begin
        make_frame(frame);
        send_frame(frame, sent);
      end
      step++;
    end

    drain();
    $display("testbench: %0d payload words in %0d frames, %0d framed words checked",
             stream.words_in, stream.frames_in, stream.words_out);
    $display("testbench: %0d stuff strings inserted across %0d register settings",
             stream.stuff_runs, settings_used);
    if (stream.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
